// ===== src/ucjk_pkg.sv =====
// Shared types, constants and helper functions of the UTF-8 CJK token checker.
package ucjk_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned FLAGS_W = 4;
    localparam int unsigned OUT_DATA_W = 40;

    localparam logic [COUNT_W-1:0] MAX_TOKEN_CHARS = 16'd65535;

    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_2BYTE   = 21'h000080;
    localparam logic [CP_W-1:0] MIN_3BYTE   = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4BYTE   = 21'h010000;
    localparam logic [CP_W-1:0] CJK_EXT_LO  = 21'h003400;
    localparam logic [CP_W-1:0] CJK_EXT_HI  = 21'h004DBF;
    localparam logic [CP_W-1:0] CJK_MAIN_LO = 21'h004E00;
    localparam logic [CP_W-1:0] CJK_MAIN_HI = 21'h009FFF;
    localparam logic [CP_W-1:0] CJK_COMP_LO = 21'h00F900;
    localparam logic [CP_W-1:0] CJK_COMP_HI = 21'h00FAFF;

    // Sequence length codes.
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_ONE  = 3'd1;
    localparam logic [2:0] SEQ_TWO  = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              token_end;
    } in_item_t;

    typedef struct packed {
        logic              char_done;
        logic [CP_W-1:0]   codepoint;
        logic              cjk_char;
        logic              decode_error;
        logic              token_done;
        logic              token_is_cjk;
        logic [COUNT_W-1:0] token_chars;
    } result_t;

    function automatic logic is_cjk(input logic [CP_W-1:0] cp);
        is_cjk = (cp >= CJK_EXT_LO  && cp <= CJK_EXT_HI)  ||
                 (cp >= CJK_MAIN_LO && cp <= CJK_MAIN_HI) ||
                 (cp >= CJK_COMP_LO && cp <= CJK_COMP_HI);
    endfunction

    function automatic logic [CP_W-1:0] min_value(input logic [2:0] seq_len);
        logic [CP_W-1:0] m;
        case (seq_len)
            SEQ_TWO:   m = MIN_2BYTE;
            SEQ_THREE: m = MIN_3BYTE;
            SEQ_FOUR:  m = MIN_4BYTE;
            default:   m = '0;
        endcase
        min_value = m;
    endfunction

endpackage

// ===== src/ucjk_in_stage.sv =====
// Input register stage: captures one byte item from the stream input.
module ucjk_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_valid,
    input  logic [7:0]          s_data,
    input  logic                s_last,
    output logic                s_ready,
    input  logic                advance,
    output logic                item_valid,
    output ucjk_pkg::in_item_t  item
);

    logic               valid_reg;
    logic               valid_next;
    ucjk_pkg::in_item_t item_reg;
    logic               load;

    assign s_ready = !valid_reg || advance;
    assign load    = s_valid && s_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.text_byte <= s_data;
            item_reg.token_end <= s_last;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== src/ucjk_decode.sv =====
// Decoder state and single-pass decode, validation and CJK classification of one byte.
module ucjk_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  ucjk_pkg::in_item_t item,
    output ucjk_pkg::result_t  result
);

    logic [1:0]                       bytes_left_reg, bytes_left_next;
    logic [2:0]                       seq_length_reg, seq_length_next;
    logic [ucjk_pkg::CP_W-1:0]        partial_reg, partial_next;
    logic [ucjk_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic                             failed_reg, failed_next;

    logic [7:0]                   b;
    logic                         complete;
    logic                         err;
    logic [ucjk_pkg::CP_W-1:0]    v;
    logic                         v_bad;
    logic                         cjk;

    always_comb
    begin
        b               = item.text_byte;
        bytes_left_next = bytes_left_reg;
        seq_length_next = seq_length_reg;
        partial_next    = partial_reg;
        count_next      = count_reg;
        failed_next     = failed_reg;
        complete        = 1'b0;
        err             = 1'b0;
        v               = '0;
        v_bad           = 1'b0;
        cjk             = 1'b0;
        result          = '0;

        if (!failed_reg)
        begin
            if (bytes_left_reg == 2'd0)
            begin
                if (!b[7])
                begin
                    partial_next    = {13'd0, b};
                    seq_length_next = ucjk_pkg::SEQ_ONE;
                    complete        = 1'b1;
                end
                else if (b[7:5] == 3'b110)
                begin
                    partial_next    = {16'd0, b[4:0]};
                    seq_length_next = ucjk_pkg::SEQ_TWO;
                    bytes_left_next = 2'd1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    partial_next    = {17'd0, b[3:0]};
                    seq_length_next = ucjk_pkg::SEQ_THREE;
                    bytes_left_next = 2'd2;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    partial_next    = {18'd0, b[2:0]};
                    seq_length_next = ucjk_pkg::SEQ_FOUR;
                    bytes_left_next = 2'd3;
                end
                else
                begin
                    err = 1'b1;
                end
            end
            else
            begin
                if (b[7:6] != 2'b10)
                begin
                    err = 1'b1;
                end
                else
                begin
                    partial_next    = {partial_reg[14:0], b[5:0]};
                    bytes_left_next = bytes_left_reg - 2'd1;
                    complete        = (bytes_left_reg == 2'd1);
                end
            end

            if (complete)
            begin
                v     = partial_next;
                v_bad = (v < ucjk_pkg::min_value(seq_length_next)) ||
                        (v > ucjk_pkg::CP_MAX) ||
                        (v >= ucjk_pkg::SURR_LO && v <= ucjk_pkg::SURR_HI);
                if (v_bad)
                begin
                    err = 1'b1;
                end
                else
                begin
                    cjk              = ucjk_pkg::is_cjk(v);
                    result.char_done = 1'b1;
                    result.codepoint = v;
                    result.cjk_char  = cjk;
                    // Non-CJK and over-limit codepoints fail the token quietly.
                    if (!cjk || count_reg >= ucjk_pkg::MAX_TOKEN_CHARS)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 16'd1;
                    end
                end
                partial_next    = '0;
                seq_length_next = ucjk_pkg::SEQ_NONE;
            end

            // A sequence still open at the token end is a truncation.
            if (item.token_end && bytes_left_next != 2'd0)
            begin
                err = 1'b1;
            end
            if (err)
            begin
                failed_next     = 1'b1;
                bytes_left_next = 2'd0;
                seq_length_next = ucjk_pkg::SEQ_NONE;
                partial_next    = '0;
            end
        end

        result.decode_error = err;
        result.token_done   = item.token_end;
        result.token_is_cjk = item.token_end && !failed_next && (count_next != '0);
        result.token_chars  = count_next;

        if (item.token_end)
        begin
            bytes_left_next = 2'd0;
            seq_length_next = ucjk_pkg::SEQ_NONE;
            partial_next    = '0;
            count_next      = '0;
            failed_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 2'd0;
            seq_length_reg <= ucjk_pkg::SEQ_NONE;
            partial_reg    <= '0;
            count_reg      <= '0;
            failed_reg     <= 1'b0;
        end
        else if (advance)
        begin
            bytes_left_reg <= bytes_left_next;
            seq_length_reg <= seq_length_next;
            partial_reg    <= partial_next;
            count_reg      <= count_next;
            failed_reg     <= failed_next;
        end
    end

endmodule

// ===== src/ucjk_out_stage.sv =====
// Result register stage: holds one result item until the receiver takes it.
module ucjk_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ucjk_pkg::result_t   result,
    output logic                free,
    input  logic                m_ready,
    output logic                m_valid,
    output ucjk_pkg::result_t   m_result
);

    logic              valid_reg;
    logic              valid_next;
    ucjk_pkg::result_t result_reg;

    assign free = !valid_reg || m_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// ===== src/utf8_cjk_token_checker_top.sv =====
// Top level of the UTF-8 CJK token checker: input stage, decoder and result stage.
//
// Usage: feed a token's UTF-8 text one byte per item on the s_axis channel,
// with s_axis_tlast high on the token's last byte. Every input item yields
// exactly one result item on the m_axis channel: a completed codepoint with
// its CJK flag, a decode fault flag, and on the last byte the token verdict
// (all clean and all CJK) with the count of codepoints in the token.
// An accepted input item passes from the input register through the decode
// logic into the result register, where its result item becomes valid; it
// waits in the input register while the result register holds an untaken item.
// Throughput is one item per cycle while the receiver does not stall; the
// decode is a single pass of mask, shift and compare logic between the two
// registers, and the decoder state advances once per item.
// Reset clears both stage valid flags and all decoder state, so the first
// byte after reset starts a new token.
// When the receiver stalls, the result register holds its item and the input
// register absorbs one more byte; s_axis_tready falls only when both are full.
module utf8_cjk_token_checker_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // token_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [ucjk_pkg::OUT_DATA_W-1:0] m_axis_tdata, // [20:0] codepoint,
                                                          // [36:21] token_chars, rest zero
    output logic [ucjk_pkg::FLAGS_W-1:0]    m_axis_tuser, // [0] char_done, [1] cjk_char,
                                                          // [2] decode_error, [3] token_is_cjk
    output logic        m_axis_tlast    // token_done
);

    ucjk_pkg::in_item_t item;
    ucjk_pkg::result_t  result;
    ucjk_pkg::result_t  m_result;
    logic               item_valid;
    logic               out_free;
    logic               advance;

    assign advance = item_valid && out_free;

    ucjk_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_data     (s_axis_tdata),
        .s_last     (s_axis_tlast),
        .s_ready    (s_axis_tready),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ucjk_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    ucjk_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .free     (out_free),
        .m_ready  (m_axis_tready),
        .m_valid  (m_axis_tvalid),
        .m_result (m_result)
    );

    assign m_axis_tdata = {3'd0, m_result.token_chars, m_result.codepoint};
    assign m_axis_tuser = {m_result.token_is_cjk, m_result.decode_error,
                           m_result.cjk_char, m_result.char_done};
    assign m_axis_tlast = m_result.token_done;

    // A codepoint is either delivered or flagged as faulty, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[2]))
        else $error("char_done and decode_error both set");

    // A CJK flag only accompanies a completed codepoint.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
        else $error("cjk_char without char_done");

    // A passing verdict only comes on the last byte of a non-empty token.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[3]) |->
            (m_axis_tlast && m_axis_tdata[36:21] != 16'd0))
        else $error("token_is_cjk outside a non-empty token end");

    // With the result register empty the pipeline must be able to take a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while result stage is empty");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the UTF-8 CJK token checker, with its own decoder prediction.
module tb_top;

    localparam int unsigned CP_W         = ucjk_pkg::CP_W;
    localparam int unsigned COUNT_W      = ucjk_pkg::COUNT_W;
    localparam int unsigned RANDOM_BYTES = 600;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned TAIL_CYCLES  = 10;
    localparam int unsigned DRAIN_EVERY  = 150;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] text_byte
    logic        s_axis_tlast = 1'b0;   // token_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // [20:0] codepoint, [36:21] token_chars, rest zero
    logic [3:0]  m_axis_tuser;          // [0] char_done, [1] cjk_char, [2] decode_error,
                                        // [3] token_is_cjk
    logic        m_axis_tlast;          // token_done

    utf8_cjk_token_checker_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Decoder state as the block should hold it.
    logic [1:0]         cont_left  = '0;
    logic [2:0]         seq_len    = ucjk_pkg::SEQ_NONE;
    logic [CP_W-1:0]    acc        = '0;
    logic [COUNT_W-1:0] char_cnt   = '0;
    logic               tok_failed = 1'b0;

    ucjk_pkg::in_item_t text_q[$];
    ucjk_pkg::result_t  decoded_q[$];
    int unsigned n_queued    = 0;
    int unsigned n_results   = 0;
    int unsigned n_mismatch  = 0;
    int unsigned tx_gap      = 0;
    int unsigned rx_stall    = 0;
    int unsigned idle_cycles = 0;
    logic        in_taken    = 1'b0;
    logic        out_taken   = 1'b0;
    logic        calm        = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic in_cjk_block(input logic [CP_W-1:0] cp);
        return (cp >= ucjk_pkg::CJK_EXT_LO  && cp <= ucjk_pkg::CJK_EXT_HI)  ||
               (cp >= ucjk_pkg::CJK_MAIN_LO && cp <= ucjk_pkg::CJK_MAIN_HI) ||
               (cp >= ucjk_pkg::CJK_COMP_LO && cp <= ucjk_pkg::CJK_COMP_HI);
    endfunction

    // Advances the predicted decoder by one byte and returns the result item it causes.
    function automatic ucjk_pkg::result_t utf8_decode_byte(input logic [7:0] b,
                                                           input logic last);
        ucjk_pkg::result_t r;
        logic              complete;
        logic              err;
        logic [CP_W-1:0]   floor_cp;
        r = '0;
        complete = 1'b0;
        err = 1'b0;
        if (!tok_failed)
        begin
            if (cont_left == 2'd0)
            begin
                if (b[7] == 1'b0)
                begin
                    acc = CP_W'(b);
                    seq_len = ucjk_pkg::SEQ_ONE;
                    complete = 1'b1;
                end
                else if (b[7:5] == 3'b110)
                begin
                    acc = CP_W'(b[4:0]);
                    seq_len = ucjk_pkg::SEQ_TWO;
                    cont_left = 2'd1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    acc = CP_W'(b[3:0]);
                    seq_len = ucjk_pkg::SEQ_THREE;
                    cont_left = 2'd2;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    acc = CP_W'(b[2:0]);
                    seq_len = ucjk_pkg::SEQ_FOUR;
                    cont_left = 2'd3;
                end
                else
                    err = 1'b1;
            end
            else if (b[7:6] != 2'b10)
                err = 1'b1;
            else
            begin
                acc = {acc[CP_W-7:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                complete = (cont_left == 2'd0);
            end

            if (complete)
            begin
                case (seq_len)
                    ucjk_pkg::SEQ_TWO:   floor_cp = ucjk_pkg::MIN_2BYTE;
                    ucjk_pkg::SEQ_THREE: floor_cp = ucjk_pkg::MIN_3BYTE;
                    ucjk_pkg::SEQ_FOUR:  floor_cp = ucjk_pkg::MIN_4BYTE;
                    default:             floor_cp = '0;
                endcase
                if (acc < floor_cp || acc > ucjk_pkg::CP_MAX ||
                    (acc >= ucjk_pkg::SURR_LO && acc <= ucjk_pkg::SURR_HI))
                    err = 1'b1;
                else
                begin
                    r.char_done = 1'b1;
                    r.codepoint = acc;
                    r.cjk_char = in_cjk_block(acc);
                    // A non-CJK codepoint or one past the count limit fails the token
                    // without being counted.
                    if (!r.cjk_char || char_cnt >= ucjk_pkg::MAX_TOKEN_CHARS)
                        tok_failed = 1'b1;
                    else
                        char_cnt = char_cnt + 16'd1;
                end
                acc = '0;
                seq_len = ucjk_pkg::SEQ_NONE;
            end

            if (!err && last && cont_left != 2'd0)
                err = 1'b1;
            if (err)
            begin
                tok_failed = 1'b1;
                cont_left = '0;
                seq_len = ucjk_pkg::SEQ_NONE;
                acc = '0;
            end
        end
        r.decode_error = err;
        r.token_done = last;
        r.token_is_cjk = last && !tok_failed && char_cnt != '0;
        r.token_chars = char_cnt;
        if (last)
        begin
            cont_left = '0;
            seq_len = ucjk_pkg::SEQ_NONE;
            acc = '0;
            char_cnt = '0;
            tok_failed = 1'b0;
        end
        return r;
    endfunction

    function automatic int unsigned min_len(input logic [CP_W-1:0] cp);
        if (cp < ucjk_pkg::MIN_2BYTE)
            return 1;
        if (cp < ucjk_pkg::MIN_3BYTE)
            return 2;
        if (cp < ucjk_pkg::MIN_4BYTE)
            return 3;
        return 4;
    endfunction

    // Mostly CJK ideographs, with some valid codepoints of every length.
    function automatic logic [CP_W-1:0] pick_cp();
        logic [CP_W-1:0] cp;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4:
                cp = CP_W'($urandom_range(ucjk_pkg::CJK_EXT_LO, ucjk_pkg::CJK_EXT_HI));
            5, 6, 7, 8, 9, 10, 11, 12:
                cp = CP_W'($urandom_range(ucjk_pkg::CJK_MAIN_LO, ucjk_pkg::CJK_MAIN_HI));
            13, 14, 15:
                cp = CP_W'($urandom_range(ucjk_pkg::CJK_COMP_LO, ucjk_pkg::CJK_COMP_HI));
            16:
                cp = CP_W'($urandom_range(0, ucjk_pkg::MIN_2BYTE - 1));
            17:
                cp = CP_W'($urandom_range(ucjk_pkg::MIN_2BYTE, ucjk_pkg::MIN_3BYTE - 1));
            18:
            begin
                cp = CP_W'($urandom_range(ucjk_pkg::MIN_3BYTE, ucjk_pkg::MIN_4BYTE - 1));
                if (cp >= ucjk_pkg::SURR_LO && cp <= ucjk_pkg::SURR_HI)
                    cp = cp ^ 21'h002000;
            end
            default:
                cp = CP_W'($urandom_range(ucjk_pkg::MIN_4BYTE, ucjk_pkg::CP_MAX));
        endcase
        return cp;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last);
        ucjk_pkg::in_item_t it;
        it.text_byte = b;
        it.token_end = last;
        text_q.push_back(it);
        n_queued++;
    endtask

    // Encodes cp in nbytes bytes; more bytes than needed give an overlong form.
    task automatic push_cp(input logic [CP_W-1:0] cp, input int unsigned nbytes,
                           input logic last);
        case (nbytes)
            1:
                push_byte({1'b0, cp[6:0]}, last);
            2:
            begin
                push_byte({3'b110, cp[10:6]}, 1'b0);
                push_byte({2'b10, cp[5:0]}, last);
            end
            3:
            begin
                push_byte({4'b1110, cp[15:12]}, 1'b0);
                push_byte({2'b10, cp[11:6]}, 1'b0);
                push_byte({2'b10, cp[5:0]}, last);
            end
            default:
            begin
                push_byte({5'b11110, cp[20:18]}, 1'b0);
                push_byte({2'b10, cp[17:12]}, 1'b0);
                push_byte({2'b10, cp[11:6]}, 1'b0);
                push_byte({2'b10, cp[5:0]}, last);
            end
        endcase
    endtask

    // Returns at a rising edge once every queued item has produced its result.
    task automatic wait_drained();
        while (n_results != n_queued)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            if (n_mismatch < 10)
                $display("result %0d: %s expected 0x%0h, got 0x%0h", n_results, name, want, got);
            n_mismatch++;
        end
    endtask

    // Byte sender.
    always @(negedge clk)
    begin : sender
        ucjk_pkg::in_item_t it;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_taken)
        begin
            if (tx_gap != 0)
            begin
                tx_gap = tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (text_q.size() != 0)
            begin
                it = text_q.pop_front();
                s_axis_tdata <= it.text_byte;
                s_axis_tlast <= it.token_end;
                s_axis_tvalid <= 1'b1;
                tx_gap = calm ? 0 : $urandom_range(0, 19);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Every accepted byte is decoded by the prediction at the same edge.
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            decoded_q.push_back(utf8_decode_byte(s_axis_tdata, s_axis_tlast));
    end

    // Result receiver: outside calm mode, stalls for a random time before taking each item.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (out_taken)
                rx_stall = calm ? 0 : $urandom_range(0, 19);
            if (rx_stall != 0)
            begin
                rx_stall = rx_stall - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        ucjk_pkg::result_t want;
        out_taken <= rst_n && m_axis_tvalid && m_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (decoded_q.size() == 0)
            begin
                if (n_mismatch < 10)
                    $display("result %0d arrived with nothing outstanding", n_results);
                n_mismatch++;
            end
            else
            begin
                want = decoded_q.pop_front();
                check_field("char_done", 32'(want.char_done), 32'(m_axis_tuser[0]));
                check_field("cjk_char", 32'(want.cjk_char), 32'(m_axis_tuser[1]));
                check_field("decode_error", 32'(want.decode_error), 32'(m_axis_tuser[2]));
                check_field("token_is_cjk", 32'(want.token_is_cjk), 32'(m_axis_tuser[3]));
                check_field("codepoint", 32'(want.codepoint), 32'(m_axis_tdata[20:0]));
                check_field("token_chars", 32'(want.token_chars), 32'(m_axis_tdata[36:21]));
                check_field("tdata padding", 32'd0, 32'(m_axis_tdata[39:37]));
                check_field("token_done", 32'(want.token_done), 32'(m_axis_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        logic [CP_W-1:0] cp;
        logic [7:0]      bad;
        logic [7:0]      seq[$];
        int unsigned     rand_base;
        int unsigned     drained_at;
        int unsigned     pick;
        int unsigned     nchars;
        int unsigned     nb;
        int unsigned     tail;
        int unsigned     i;
        int unsigned     j;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed tokens.
        push_byte(8'hFF, 1'b1);
        push_cp(ucjk_pkg::CJK_EXT_LO, 3, 1'b0);
        push_cp(ucjk_pkg::CJK_COMP_HI, 3, 1'b1);
        push_cp('0, 2, 1'b1);
        push_cp(ucjk_pkg::SURR_LO, 3, 1'b1);
        push_cp(ucjk_pkg::CP_MAX + 1'b1, 4, 1'b1);
        push_byte(8'hE4, 1'b0);
        push_byte(8'h41, 1'b1);
        // A non-CJK character fails the token; the rest is skipped, not truncated.
        push_cp(ucjk_pkg::CJK_MAIN_LO, 3, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hE4, 1'b0);
        push_byte(8'hB8, 1'b1);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h9F, 1'b1);
        wait_drained();

        rand_base = n_queued;
        drained_at = n_queued;
        while (n_queued - rand_base < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 7) == 0)
                calm = ~calm;
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                nchars = $urandom_range(1, 6);
                for (i = 1; i <= nchars; i++)
                begin
                    cp = pick_cp();
                    push_cp(cp, min_len(cp), i == nchars);
                end
            end
            else if (pick < 90)
            begin
                nchars = $urandom_range(0, 3);
                for (i = 0; i < nchars; i++)
                begin
                    cp = pick_cp();
                    push_cp(cp, min_len(cp), 1'b0);
                end
                tail = $urandom_range(0, 4);
                case ($urandom_range(0, 4))
                    0:
                    begin
                        nb = $urandom_range(2, 4);
                        cp = (nb == 2) ? CP_W'($urandom_range(0, ucjk_pkg::MIN_2BYTE - 1)) :
                             (nb == 3) ? CP_W'($urandom_range(0, ucjk_pkg::MIN_3BYTE - 1)) :
                                         CP_W'($urandom_range(0, ucjk_pkg::MIN_4BYTE - 1));
                        push_cp(cp, nb, tail == 0);
                    end
                    1:
                        push_cp(CP_W'($urandom_range(ucjk_pkg::SURR_LO, ucjk_pkg::SURR_HI)),
                                3, tail == 0);
                    2:
                        push_cp(CP_W'($urandom_range(ucjk_pkg::CP_MAX + 1'b1, 21'h1FFFFF)),
                                4, tail == 0);
                    3:
                        push_byte(8'($urandom_range(0, 1) ? $urandom_range(8'h80, 8'hBF) :
                                     $urandom_range(8'hF8, 8'hFF)), tail == 0);
                    default:
                    begin
                        // An open sequence that either meets a bad continuation byte
                        // or is cut off by the token end.
                        nb = $urandom_range(2, 4);
                        seq.delete();
                        seq.push_back((nb == 2) ? {3'b110, 5'($urandom)} :
                                      (nb == 3) ? {4'b1110, 4'($urandom)} :
                                                  {5'b11110, 3'($urandom)});
                        repeat ($urandom_range(0, nb - 2))
                            seq.push_back({2'b10, 6'($urandom)});
                        if ($urandom_range(0, 1))
                            tail = 0;
                        else
                        begin
                            bad = 8'($urandom);
                            if (bad[7:6] == 2'b10)
                                bad[6] = 1'b1;
                            seq.push_back(bad);
                        end
                        for (j = 0; j < seq.size(); j++)
                            push_byte(seq[j], tail == 0 && j == seq.size() - 1);
                    end
                endcase
                for (i = 1; i <= tail; i++)
                    push_byte(8'($urandom), i == tail);
            end
            else
            begin
                nb = $urandom_range(1, 8);
                for (i = 1; i <= nb; i++)
                    push_byte(8'($urandom), i == nb);
            end

            // Keep the sender close to the queue so each token sees its own idling mode.
            while (text_q.size() != 0)
                @(posedge clk);
            if (n_queued - drained_at >= DRAIN_EVERY)
            begin
                wait_drained();
                drained_at = n_queued;
            end
        end
        calm = 1'b0;
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (n_mismatch == 0 && decoded_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
